[hdl/skfk_pkg.sv]
// ----------------------------------------------------------------------------
// skfk_pkg
// Shared types, constants and saturation helpers for the skeleton forward
// kinematics unit.
// ----------------------------------------------------------------------------
package skfk_pkg;

	localparam int unsigned MAX_BONES_DEF = 256;
	localparam int unsigned QUAT_FRAC     = 14;

	localparam logic REQ_ROOT  = 1'b0;
	localparam logic REQ_CHILD = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [7:0]         bone_slot;
		logic [7:0]         parent_slot;
		logic signed [31:0] local_pos_x;
		logic signed [31:0] local_pos_y;
		logic signed [31:0] local_pos_z;
		logic signed [31:0] local_pos_w;
		logic signed [15:0] local_rot_w;
		logic signed [15:0] local_rot_x;
		logic signed [15:0] local_rot_y;
		logic signed [15:0] local_rot_z;
	} req_t;

	typedef struct packed {
		logic [7:0]         out_slot;
		logic signed [31:0] model_pos_x;
		logic signed [31:0] model_pos_y;
		logic signed [31:0] model_pos_z;
		logic signed [31:0] model_pos_w;
		logic signed [15:0] model_rot_w;
		logic signed [15:0] model_rot_x;
		logic signed [15:0] model_rot_y;
		logic signed [15:0] model_rot_z;
	} rsp_t;

	// One pose table row: model-space transform of one bone
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_w;
		logic signed [15:0] rot_w;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
	} pose_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // latch request, issue parent read
		logic mul1;   // cross products and quaternion products
		logic trunc;  // round cross terms, finish quaternion
		logic mul2;   // second cross products
		logic fin;    // load result register, write pose table
	} cmd_t;

	function automatic logic signed [31:0] sat_pos(input logic signed [41:0] x);
		logic signed [31:0] r;
		if (x[41:31] == {11{x[41]}}) begin
			r = x[31:0];
		end else begin
			r = x[41] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat_rot(input logic signed [20:0] x);
		logic signed [15:0] r;
		if (x[20:15] == {6{x[20]}}) begin
			r = x[15:0];
		end else begin
			r = x[20] ? 16'sh8000 : 16'sh7fff;
		end
		return r;
	endfunction

endpackage

[hdl/skfk_stream_if.sv]
// ----------------------------------------------------------------------------
// skfk_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface skfk_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/skfk_ctrl.sv]
// ----------------------------------------------------------------------------
// skfk_ctrl
// Sequencer: steps one bone through read, multiply, round, multiply again
// and finish, and owns the result valid flag.
// ----------------------------------------------------------------------------
module skfk_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output skfk_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL1,
		ST_TRUNC,
		ST_MUL2,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   fin_go;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	// finish only when the result register is free or being drained
	assign fin_go    = (state_q == ST_FIN) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == ST_IDLE) && req_valid;
		cmd.mul1  = (state_q == ST_READ);
		cmd.trunc = (state_q == ST_MUL1);
		cmd.mul2  = (state_q == ST_TRUNC);
		cmd.fin   = fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_READ;
				end
				ST_READ:  state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_TRUNC;
				ST_TRUNC: state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase

			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/skfk_dp.sv]
// ----------------------------------------------------------------------------
// skfk_dp
// Datapath: pose table, vector rotation by the parent quaternion, Hamilton
// product, rounding and saturation, result register.
// ----------------------------------------------------------------------------
module skfk_dp #(
	parameter int unsigned MAX_BONES = skfk_pkg::MAX_BONES_DEF
) (
	input  logic            clk,
	input  skfk_pkg::cmd_t  cmd,
	input  skfk_pkg::req_t  req,
	output skfk_pkg::rsp_t  rsp
);

	localparam int unsigned IDX_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

	skfk_pkg::pose_t mem [MAX_BONES];

	skfk_pkg::req_t  in_q;
	logic            par_ok_q;
	skfk_pkg::pose_t rd_q;
	skfk_pkg::rsp_t  rsp_q;

	logic signed [15:0] aw, ax, ay, az;
	logic signed [31:0] px, py, pz, pw;

	logic signed [47:0] cp_s1 [6];
	logic signed [31:0] qp_s1 [4][4];
	logic signed [35:0] t_s2  [3];
	logic signed [15:0] q_s2  [4];
	logic signed [51:0] sp_s3 [9];

	logic signed [31:0] lrot [4];
	logic signed [15:0] arot [4];
	logic signed [49:0] dx, dy, dz;
	logic signed [34:0] qsum [4];
	logic signed [53:0] ux, uy, uz;
	logic signed [41:0] rx, ry, rz, rw;
	logic               bone_ok;
	skfk_pkg::pose_t    wr;

	// parent outside the table reads as zero
	always_comb begin
		aw = par_ok_q ? rd_q.rot_w : '0;
		ax = par_ok_q ? rd_q.rot_x : '0;
		ay = par_ok_q ? rd_q.rot_y : '0;
		az = par_ok_q ? rd_q.rot_z : '0;
		px = par_ok_q ? rd_q.pos_x : '0;
		py = par_ok_q ? rd_q.pos_y : '0;
		pz = par_ok_q ? rd_q.pos_z : '0;
		pw = par_ok_q ? rd_q.pos_w : '0;
		arot[0] = aw; arot[1] = ax; arot[2] = ay; arot[3] = az;
		lrot[0] = 32'(in_q.local_rot_w);
		lrot[1] = 32'(in_q.local_rot_x);
		lrot[2] = 32'(in_q.local_rot_y);
		lrot[3] = 32'(in_q.local_rot_z);
	end

	// request latch and parent read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q     <= req;
			par_ok_q <= (32'(req.parent_slot) < MAX_BONES);
			rd_q     <= mem[IDX_W'(req.parent_slot)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin && bone_ok) begin
			mem[IDX_W'(in_q.bone_slot)] <= wr;
		end
	end

	// stage 1: u x v products and the sixteen quaternion products
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			cp_s1[0] <= ay * in_q.local_pos_z;
			cp_s1[1] <= az * in_q.local_pos_y;
			cp_s1[2] <= az * in_q.local_pos_x;
			cp_s1[3] <= ax * in_q.local_pos_z;
			cp_s1[4] <= ax * in_q.local_pos_y;
			cp_s1[5] <= ay * in_q.local_pos_x;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					qp_s1[i][j] <= 32'(arot[i]) * lrot[j];
				end
			end
		end
	end

	// stage 2: round t back to vector scale, round and saturate the rotation
	always_comb begin
		dx = 50'(cp_s1[0]) - 50'(cp_s1[1]) + 50'sd8192;
		dy = 50'(cp_s1[2]) - 50'(cp_s1[3]) + 50'sd8192;
		dz = 50'(cp_s1[4]) - 50'(cp_s1[5]) + 50'sd8192;
		qsum[0] = 35'(qp_s1[0][0]) - 35'(qp_s1[1][1]) - 35'(qp_s1[2][2])
			- 35'(qp_s1[3][3]) + 35'sd8192;
		qsum[1] = 35'(qp_s1[0][1]) + 35'(qp_s1[1][0]) + 35'(qp_s1[2][3])
			- 35'(qp_s1[3][2]) + 35'sd8192;
		qsum[2] = 35'(qp_s1[0][2]) - 35'(qp_s1[1][3]) + 35'(qp_s1[2][0])
			+ 35'(qp_s1[3][1]) + 35'sd8192;
		qsum[3] = 35'(qp_s1[0][3]) + 35'(qp_s1[1][2]) - 35'(qp_s1[2][1])
			+ 35'(qp_s1[3][0]) + 35'sd8192;
	end

	always_ff @(posedge clk) begin
		if (cmd.trunc) begin
			t_s2[0] <= dx[49:14];
			t_s2[1] <= dy[49:14];
			t_s2[2] <= dz[49:14];
			for (int k = 0; k < 4; k++) begin
				q_s2[k] <= skfk_pkg::sat_rot(qsum[k][34:14]);
			end
		end
	end

	// stage 3: w*t + u x t products
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			sp_s3[0] <= aw * t_s2[0];
			sp_s3[1] <= ay * t_s2[2];
			sp_s3[2] <= az * t_s2[1];
			sp_s3[3] <= aw * t_s2[1];
			sp_s3[4] <= az * t_s2[0];
			sp_s3[5] <= ax * t_s2[2];
			sp_s3[6] <= aw * t_s2[2];
			sp_s3[7] <= ax * t_s2[1];
			sp_s3[8] <= ay * t_s2[0];
		end
	end

	// stage 4: 2*s rounded, plus local and parent translation, saturate
	always_comb begin
		ux = 54'(sp_s3[0]) + 54'(sp_s3[1]) - 54'(sp_s3[2]) + 54'sd4096;
		uy = 54'(sp_s3[3]) + 54'(sp_s3[4]) - 54'(sp_s3[5]) + 54'sd4096;
		uz = 54'(sp_s3[6]) + 54'(sp_s3[7]) - 54'(sp_s3[8]) + 54'sd4096;
		rx = 42'(in_q.local_pos_x) + 42'($signed(ux[53:13])) + 42'(px);
		ry = 42'(in_q.local_pos_y) + 42'($signed(uy[53:13])) + 42'(py);
		rz = 42'(in_q.local_pos_z) + 42'($signed(uz[53:13])) + 42'(pz);
		rw = 42'(in_q.local_pos_w) + 42'(pw);
		bone_ok = (32'(in_q.bone_slot) < MAX_BONES);

		if (in_q.req_type == skfk_pkg::REQ_ROOT) begin
			wr.pos_x = in_q.local_pos_x;
			wr.pos_y = in_q.local_pos_y;
			wr.pos_z = in_q.local_pos_z;
			wr.pos_w = in_q.local_pos_w;
			wr.rot_w = in_q.local_rot_w;
			wr.rot_x = in_q.local_rot_x;
			wr.rot_y = in_q.local_rot_y;
			wr.rot_z = in_q.local_rot_z;
		end else begin
			wr.pos_x = skfk_pkg::sat_pos(rx);
			wr.pos_y = skfk_pkg::sat_pos(ry);
			wr.pos_z = skfk_pkg::sat_pos(rz);
			wr.pos_w = skfk_pkg::sat_pos(rw);
			wr.rot_w = q_s2[0];
			wr.rot_x = q_s2[1];
			wr.rot_y = q_s2[2];
			wr.rot_z = q_s2[3];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q.out_slot    <= in_q.bone_slot;
			rsp_q.model_pos_x <= wr.pos_x;
			rsp_q.model_pos_y <= wr.pos_y;
			rsp_q.model_pos_z <= wr.pos_z;
			rsp_q.model_pos_w <= wr.pos_w;
			rsp_q.model_rot_w <= wr.rot_w;
			rsp_q.model_rot_x <= wr.rot_x;
			rsp_q.model_rot_y <= wr.rot_y;
			rsp_q.model_rot_z <= wr.rot_z;
		end
	end

	assign rsp = rsp_q;

endmodule

[hdl/skeleton_forward_kinematics_unit.sv]
// ----------------------------------------------------------------------------
// skeleton_forward_kinematics_unit
// Model-space pose of a bone hierarchy from local translations and rotations.
// ----------------------------------------------------------------------------
// Send bones parent first. A root request is stored and echoed as given; a
// child request rotates its local xyz by the parent's quaternion, adds the
// parent translation and w, and takes parent * local as its rotation, all
// saturated, then stores the result at its slot. The unit works on one bone
// at a time: the pose table is read on the accepting edge, and the result
// reaches the output register through a first multiply stage, a rounding
// stage, a second multiply stage, a spare state and a finish stage that
// writes the table; the next request is taken once the unit is back in
// idle after the finish stage. If the previous result still waits to be
// taken, the finish stage holds until it drains. A parent slot must have been
// written before a child reads it.
module skeleton_forward_kinematics_unit #(
	parameter int unsigned MAX_BONES = skfk_pkg::MAX_BONES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	skfk_stream_if.sink   req,
	skfk_stream_if.source rsp
);

	skfk_pkg::cmd_t cmd;

	skfk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	skfk_dp #(
		.MAX_BONES (MAX_BONES)
	) u_dp (
		.clk (clk),
		.cmd (cmd),
		.req (req.payload),
		.rsp (rsp.payload)
	);

endmodule
